// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top level RTL file of the synapse unit.
// Holds only macro definitions and comments.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- hw/rtl/dsdes_pkg.sv -----
// Package of the delayed spike synapse unit: payload types, codes, helpers.
// Depends on nothing.
package dsdes_pkg;
	localparam logic [1:0] REQ_SPIKE = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_LOAD  = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	localparam logic [2:0] REG_X_IN    = 3'd0;
	localparam logic [2:0] REG_X_DECAY = 3'd1;
	localparam logic [2:0] REG_Y_IN    = 3'd2;
	localparam logic [2:0] REG_Y_DECAY = 3'd3;
	localparam logic [2:0] REG_NORM    = 3'd4;
	localparam logic [2:0] REG_REV     = 3'd5;
	localparam logic [2:0] REG_INV_DT  = 3'd6;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [5:0]         syn_index;
		logic [31:0]        event_time;
		logic signed [15:0] entry_weight;
		logic [15:0]        entry_delay;
		logic signed [31:0] vm;
		logic signed [31:0] ext_activation;
		logic signed [31:0] modulation;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] conductance;
		logic signed [31:0] current;
		logic [6:0]         events_applied;
		logic               overflow_seen;
	} out_word_t;

	// Coefficient set handed from the register file to the datapath.
	typedef struct packed {
		logic [31:0] x_in;
		logic [31:0] x_decay;
		logic [31:0] y_in;
		logic [31:0] y_decay;
		logic [31:0] norm;
		logic [31:0] rev;
		logic [31:0] inv_dt;
	} coef_t;

	// Clamp a 66-bit signed value to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647) r = 32'sh7fffffff;
		else if (v < -66'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction
endpackage

// ----- hw/rtl/dsdes_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
// Depends on nothing.
module dsdes_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/dsdes_regs.sv -----
// APB register file holding the filter and scaling coefficients.
// Depends on dsdes_pkg.
module dsdes_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [4:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output dsdes_pkg::coef_t coef
);
	logic [2:0] idx;
	logic       wr;
	assign idx = paddr[4:2];
	assign wr  = psel && penable && pwrite;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef <= '0;
		end else if (wr) begin
			unique case (idx)
				dsdes_pkg::REG_X_IN:    coef.x_in <= pwdata;
				dsdes_pkg::REG_X_DECAY: coef.x_decay <= pwdata;
				dsdes_pkg::REG_Y_IN:    coef.y_in <= pwdata;
				dsdes_pkg::REG_Y_DECAY: coef.y_decay <= pwdata;
				dsdes_pkg::REG_NORM:    coef.norm <= pwdata;
				dsdes_pkg::REG_REV:     coef.rev <= pwdata;
				dsdes_pkg::REG_INV_DT:  coef.inv_dt <= pwdata;
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		unique case (idx)
			dsdes_pkg::REG_X_IN:    prdata = coef.x_in;
			dsdes_pkg::REG_X_DECAY: prdata = coef.x_decay;
			dsdes_pkg::REG_Y_IN:    prdata = coef.y_in;
			dsdes_pkg::REG_Y_DECAY: prdata = coef.y_decay;
			dsdes_pkg::REG_NORM:    prdata = coef.norm;
			dsdes_pkg::REG_REV:     prdata = coef.rev;
			dsdes_pkg::REG_INV_DT:  prdata = coef.inv_dt;
			default:                prdata = '0;
		endcase
	end
endmodule

// ----- hw/rtl/delayed_spike_dual_exp_synapse_unit.sv -----
// Top level of the delayed spike dual-exponential synapse unit.
// Depends on dsdes_pkg, dsdes_ram, dsdes_regs and assert_macros.svh.
//
// channel  | ports                              | handshake
// request  | start, busy, req                   | taken when start && !busy
// result   | done, result                       | one-cycle strobe, no stall
// config   | psel penable pwrite paddr pwdata   | APB, pready always high
//
// A spike passes from acceptance through a table read and a queue write before
// the next request can be taken; a load, a clear or a dropped spike leaves the
// unit idle.
// A tick sweeps the queue memories one slot a cycle and compacts them in place,
// then a sequencer runs the filter chain through one shared 33x33 multiplier in
// 12 steps, one product a cycle. done rises in the first cycle that busy is low
// again. After reset the synapse tables are cleared by a pass over all
// NUM_SYNAPSES entries during which busy is high. The result cannot be stalled.
`include "assert_macros.svh"
module delayed_spike_dual_exp_synapse_unit #(
	parameter int NUM_SYNAPSES = 64,
	parameter int QUEUE_DEPTH  = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  dsdes_pkg::in_word_t   req,
	output logic                  done,
	output dsdes_pkg::out_word_t  result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [4:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	localparam int SW = (NUM_SYNAPSES > 1) ? $clog2(NUM_SYNAPSES) : 1;
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [3:0] ST_INIT  = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_TRD   = 4'd2;
	localparam logic [3:0] ST_TWR   = 4'd3;
	localparam logic [3:0] ST_SWEEP = 4'd4;
	localparam logic [3:0] ST_MATH  = 4'd5;

	dsdes_pkg::coef_t coef;
	dsdes_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .coef
	);
	assign pready = 1'b1;

	logic [3:0]  state_q;
	logic        accept;
	dsdes_pkg::in_word_t req_q;
	logic [CW-1:0] count_q, rd_q, keep_q, applied_q;
	logic        rvalid_q;
	logic [SW-1:0] init_q;
	logic        ovf_q;
	logic signed [31:0] fx_q, fy_q;
	logic signed [65:0] act_q;
	logic [3:0]  step_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Synapse table: weight and delay side by side.
	logic          tab_we;
	logic [SW-1:0] tab_waddr, tab_raddr;
	logic [31:0]   tab_wdata, tab_rdata;
	dsdes_ram #(.WIDTH(32), .DEPTH(NUM_SYNAPSES)) u_tab (
		.clk, .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
		.raddr(tab_raddr), .rdata(tab_rdata)
	);

	// Event queue: due time and weight side by side.
	logic          q_we;
	logic [QW-1:0] q_waddr, q_raddr;
	logic [47:0]   q_wdata, q_rdata;
	dsdes_ram #(.WIDTH(48), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rdata)
	);

	logic idx_ok;
	assign idx_ok = ({26'd0, req.syn_index} < 32'(NUM_SYNAPSES));

	logic [32:0] due_sum;
	assign due_sum = {1'b0, req_q.event_time} + {17'd0, tab_rdata[15:0]};

	logic q_due;
	assign q_due = (q_rdata[47:16] <= req_q.event_time);

	// Table port control. While a spike is in flight the read follows the held word.
	always_comb begin
		tab_we    = 1'b0;
		tab_waddr = SW'(req.syn_index);
		tab_wdata = {req.entry_weight, req.entry_delay};
		tab_raddr = (state_q == ST_IDLE) ? SW'(req.syn_index) : SW'(req_q.syn_index);
		if (state_q == ST_INIT) begin
			tab_we    = 1'b1;
			tab_waddr = init_q;
			tab_wdata = '0;
		end else if (accept && req.req_type == dsdes_pkg::REQ_LOAD && idx_ok) begin
			tab_we = 1'b1;
		end
	end

	// Queue port control: spike push or compaction write during sweep.
	always_comb begin
		q_we    = 1'b0;
		q_waddr = count_q[QW-1:0];
		q_wdata = {(due_sum[32] ? 32'hffffffff : due_sum[31:0]), tab_rdata[31:16]};
		q_raddr = rd_q[QW-1:0];
		if (state_q == ST_TWR) begin
			q_we = 1'b1;
		end else if (state_q == ST_SWEEP && rvalid_q && !q_due) begin
			q_we    = 1'b1;
			q_waddr = keep_q[QW-1:0];
			q_wdata = q_rdata;
		end
	end

	// Shared multiplier: 33x33 signed, one product a cycle, registered.
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod_q;
	logic signed [31:0] m_q, a_q;

	logic signed [31:0] sat_act;
	assign sat_act = dsdes_pkg::sat32(act_q);

	// Operand select; each product is taken from the product register prod_q by the sequencer.
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (step_q)
			4'd0: begin ma = {sat_act[31], sat_act}; mb = {req_q.modulation[31], req_q.modulation}; end
			4'd2: begin ma = {m_q[31], m_q}; mb = {1'b0, coef.x_in}; end
			4'd3: begin ma = {fx_q[31], fx_q}; mb = {1'b0, coef.x_decay}; end
			4'd5: begin ma = {fx_q[31], fx_q}; mb = {1'b0, coef.y_in}; end
			4'd6: begin ma = {fy_q[31], fy_q}; mb = {1'b0, coef.y_decay}; end
			4'd8: begin ma = {fy_q[31], fy_q}; mb = {1'b0, coef.norm}; end
			4'd10: begin
				ma = {coef.rev[31], coef.rev} - {req_q.vm[31], req_q.vm};
				mb = {m_q[31], m_q};
			end
			default: ;
		endcase
	end

	// Event weight scaled by inv_dt, floor shift by 8.
	logic signed [49:0] wprod;
	assign wprod = $signed(q_rdata[15:0]) * $signed({1'b0, coef.inv_dt});

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			init_q    <= '0;
			count_q   <= '0;
			rd_q      <= '0;
			keep_q    <= '0;
			applied_q <= '0;
			rvalid_q  <= 1'b0;
			ovf_q     <= 1'b0;
			fx_q      <= '0;
			fy_q      <= '0;
			m_q       <= '0;
			a_q       <= '0;
			step_q    <= '0;
			result    <= '0;
			done      <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					init_q <= init_q + 1'b1;
					if (32'(init_q) == NUM_SYNAPSES - 1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (req.req_type)
							dsdes_pkg::REQ_SPIKE: begin
								if (idx_ok) begin
									if (32'(count_q) >= QUEUE_DEPTH) ovf_q <= 1'b1;
									else state_q <= ST_TRD;
								end
							end
							dsdes_pkg::REQ_TICK: begin
								state_q   <= ST_SWEEP;
								rd_q      <= '0;
								keep_q    <= '0;
								applied_q <= '0;
								rvalid_q  <= 1'b0;
							end
							dsdes_pkg::REQ_LOAD: ;
							dsdes_pkg::REQ_CLEAR: begin
								count_q <= '0;
								fx_q    <= '0;
								fy_q    <= '0;
								ovf_q   <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_TRD: state_q <= ST_TWR;
				ST_TWR: begin
					count_q <= count_q + 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SWEEP: begin
					if (rvalid_q) begin
						if (q_due) applied_q <= applied_q + 1'b1;
						else keep_q <= keep_q + 1'b1;
					end
					if (rd_q < count_q) begin
						rd_q     <= rd_q + 1'b1;
						rvalid_q <= 1'b1;
					end else begin
						rvalid_q <= 1'b0;
						if (!rvalid_q) begin
							count_q <= keep_q;
							state_q <= ST_MATH;
							step_q  <= '0;
						end
					end
				end
				ST_MATH: begin
					step_q <= step_q + 1'b1;
					unique case (step_q)
						4'd1: m_q <= dsdes_pkg::sat32(prod_q >>> 16);
						4'd3: a_q <= dsdes_pkg::sat32(prod_q >>> 16);
						4'd4: fx_q <= dsdes_pkg::sat32(66'(a_q) + (prod_q >>> 32));
						4'd6: a_q <= dsdes_pkg::sat32(prod_q >>> 16);
						4'd7: fy_q <= dsdes_pkg::sat32(66'(a_q) + (prod_q >>> 32));
						4'd9: m_q <= dsdes_pkg::sat32(prod_q >>> 16);
						4'd11: begin
							result.conductance    <= m_q;
							result.current        <= dsdes_pkg::sat32(prod_q >>> 16);
							result.events_applied <= 7'(applied_q);
							result.overflow_seen  <= ovf_q;
							done    <= 1'b1;
							state_q <= ST_IDLE;
						end
						default: ;
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers: request copy, activation accumulator, product.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			act_q <= 66'(req.ext_activation);
		end
		if (state_q == ST_SWEEP && rvalid_q && q_due) act_q <= act_q + 66'(wprod >>> 8);
		prod_q <= ma * mb;
	end

	logic tick_go;
	assign tick_go = accept && req.req_type == dsdes_pkg::REQ_TICK;

	`ASSERT_IMPL(a_done_from_math, clk, arst_n, done, $past(state_q) == ST_MATH)
	`ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, 32'(count_q) <= QUEUE_DEPTH)
	`ASSERT_IMPL(a_keep_le_rd, clk, arst_n, state_q == ST_SWEEP, keep_q + applied_q <= rd_q)
	`ASSERT_NEXT(a_busy_after_tick, clk, arst_n, tick_go, busy)
endmodule

// ----- tb/delayed_spike_dual_exp_synapse_unit_test.sv -----
// Self-checking testbench of the delayed spike dual-exponential synapse unit.
// Depends on dsdes_pkg and on the top level delayed_spike_dual_exp_synapse_unit.
`timescale 1ns / 100ps
module delayed_spike_dual_exp_synapse_unit_test;
	localparam int SYN_COUNT   = 64;
	localparam int QUEUE_SLOTS = 64;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	dsdes_pkg::in_word_t req = '0;
	logic done;
	dsdes_pkg::out_word_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	delayed_spike_dual_exp_synapse_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	// Channel state mirrored by the predictor.
	logic [31:0] coef [0:6];
	logic signed [15:0] tbl_weight [0:SYN_COUNT-1];
	logic [15:0] tbl_delay [0:SYN_COUNT-1];
	logic [31:0] q_due [0:QUEUE_SLOTS-1];
	logic signed [15:0] q_weight [0:QUEUE_SLOTS-1];
	int q_count;
	longint filt_x, filt_y;
	logic drop_flag;

	dsdes_pkg::in_word_t pending_words [$];
	dsdes_pkg::out_word_t expected_words [$];
	int mismatches = 0;
	int ticks_checked = 0;
	int drops_seen = 0;
	int cycles = 0;
	bit quiet_sender = 1'b0;
	int gap_left = 0;
	logic [31:0] cur_time;

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Apply one accepted word to the mirrored state; a tick yields one result.
	task automatic apply_word(input dsdes_pkg::in_word_t w);
		longint act, m, a, b, g, cur, wt, rate, vmv, rev;
		longint due;
		int keep, applied;
		dsdes_pkg::out_word_t o;
		case (w.req_type)
			dsdes_pkg::REQ_SPIKE: begin
				if (q_count >= QUEUE_SLOTS) begin
					drop_flag = 1'b1;
					drops_seen++;
				end else begin
					due = longint'(w.event_time) + longint'(tbl_delay[w.syn_index]);
					if (due > 64'sd4294967295) due = 64'sd4294967295;
					q_due[q_count] = due[31:0];
					q_weight[q_count] = tbl_weight[w.syn_index];
					q_count++;
				end
			end
			dsdes_pkg::REQ_LOAD: begin
				tbl_weight[w.syn_index] = w.entry_weight;
				tbl_delay[w.syn_index] = w.entry_delay;
			end
			dsdes_pkg::REQ_CLEAR: begin
				q_count = 0;
				filt_x = 0;
				filt_y = 0;
				drop_flag = 1'b0;
			end
			default: begin
				act = longint'(w.ext_activation);
				rate = longint'(coef[dsdes_pkg::REG_INV_DT]);
				keep = 0;
				applied = 0;
				for (int i = 0; i < q_count; i++) begin
					if (q_due[i] <= w.event_time) begin
						wt = longint'(q_weight[i]);
						act += (wt * rate) >>> 8;
						applied++;
					end else begin
						q_due[keep] = q_due[i];
						q_weight[keep] = q_weight[i];
						keep++;
					end
				end
				q_count = keep;
				act = clamp32(act);
				m = clamp32((longint'(w.modulation) * act) >>> 16);
				a = clamp32((m * longint'(coef[dsdes_pkg::REG_X_IN])) >>> 16);
				b = (filt_x * longint'(coef[dsdes_pkg::REG_X_DECAY])) >>> 32;
				filt_x = clamp32(a + b);
				a = clamp32((filt_x * longint'(coef[dsdes_pkg::REG_Y_IN])) >>> 16);
				b = (filt_y * longint'(coef[dsdes_pkg::REG_Y_DECAY])) >>> 32;
				filt_y = clamp32(a + b);
				g = clamp32((filt_y * longint'(coef[dsdes_pkg::REG_NORM])) >>> 16);
				rev = longint'($signed(coef[dsdes_pkg::REG_REV]));
				vmv = longint'(w.vm);
				cur = clamp32(((rev - vmv) * g) >>> 16);
				o.conductance = g[31:0];
				o.current = cur[31:0];
				o.events_applied = applied[6:0];
				o.overflow_seen = drop_flag;
				expected_words.push_back(o);
			end
		endcase
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// Driver: presents pending words with random gaps and mirrors each acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else begin
			if (start && !busy) apply_word(req);
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (pending_words.size() > 0) begin
					req <= pending_words.pop_front();
					start <= 1'b1;
					if (quiet_sender) gap_left <= 0;
					else gap_left <= pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every result strobe is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", result);
			end else begin
				dsdes_pkg::out_word_t e;
				e = expected_words.pop_front();
				ticks_checked++;
				if (e.conductance !== result.conductance || e.current !== result.current ||
					e.events_applied !== result.events_applied ||
					e.overflow_seen !== result.overflow_seen) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp g=%h i=%h n=%0d ov=%b got g=%h i=%h n=%0d ov=%b",
							e.conductance, e.current, e.events_applied, e.overflow_seen,
							result.conductance, result.current, result.events_applied,
							result.overflow_seen);
				end
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		coef[idx] = v;
	endtask

	// Block until everything sent has been accepted and answered.
	task automatic wait_idle();
		while (pending_words.size() > 0 || start || busy || expected_words.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Coefficient sets: 0 typical, 1 all ones but rev at an extreme, 2 all zero, 3 any value.
	task automatic set_coefs(input int kind);
		logic [31:0] v [0:6];
		case (kind)
			0: begin
				v[0] = $urandom_range(32'h8000, 32'h40000);
				v[1] = $urandom_range(32'hC0000000, 32'hFFFF0000);
				v[2] = $urandom_range(32'h8000, 32'h40000);
				v[3] = $urandom_range(32'hC0000000, 32'hFFFF0000);
				v[4] = $urandom_range(32'h4000, 32'h30000);
				v[5] = $urandom_range(0, 32'hA00000) - 32'h500000;
				v[6] = $urandom_range(32'h10000, 32'hA0000);
			end
			1: begin
				foreach (v[i]) v[i] = 32'hFFFFFFFF;
				v[5] = ($urandom_range(0, 1) != 0) ? 32'h7FFFFFFF : 32'h80000000;
			end
			2: foreach (v[i]) v[i] = 32'h0;
			default: foreach (v[i]) v[i] = $urandom;
		endcase
		write_reg(dsdes_pkg::REG_X_IN, v[0]);
		write_reg(dsdes_pkg::REG_X_DECAY, v[1]);
		write_reg(dsdes_pkg::REG_Y_IN, v[2]);
		write_reg(dsdes_pkg::REG_Y_DECAY, v[3]);
		write_reg(dsdes_pkg::REG_NORM, v[4]);
		write_reg(dsdes_pkg::REG_REV, v[5]);
		write_reg(dsdes_pkg::REG_INV_DT, v[6]);
	endtask

	function automatic dsdes_pkg::in_word_t mk_load(input int idx, input logic [15:0] w,
		input logic [15:0] d);
		dsdes_pkg::in_word_t x;
		x = '0;
		x.req_type = dsdes_pkg::REQ_LOAD;
		x.syn_index = idx[5:0];
		x.entry_weight = w;
		x.entry_delay = d;
		return x;
	endfunction

	function automatic dsdes_pkg::in_word_t mk_spike(input int idx, input logic [31:0] t);
		dsdes_pkg::in_word_t x;
		x = '0;
		x.req_type = dsdes_pkg::REQ_SPIKE;
		x.syn_index = idx[5:0];
		x.event_time = t;
		return x;
	endfunction

	function automatic dsdes_pkg::in_word_t mk_tick(input logic [31:0] t,
		input logic [31:0] vmv, input logic [31:0] ext, input logic [31:0] md);
		dsdes_pkg::in_word_t x;
		x = '0;
		x.req_type = dsdes_pkg::REQ_TICK;
		x.event_time = t;
		x.vm = vmv;
		x.ext_activation = ext;
		x.modulation = md;
		return x;
	endfunction

	function automatic dsdes_pkg::in_word_t mk_clear();
		dsdes_pkg::in_word_t x;
		x = '0;
		x.req_type = dsdes_pkg::REQ_CLEAR;
		return x;
	endfunction

	// Random traffic: loads, spikes around the running time, spike floods, ticks, clears, noise.
	task automatic add_random(input int target);
		int added, r, burst;
		logic [31:0] ext, md, vmv;
		logic [191:0] noise;
		dsdes_pkg::in_word_t x;
		added = 0;
		while (added < target) begin
			r = $urandom_range(0, 99);
			if (r < 2) begin
				// Flood the queue near or past its depth to provoke drops.
				burst = $urandom_range(60, 72);
				for (int i = 0; i < burst; i++)
					pending_words.push_back(mk_spike($urandom_range(0, 63),
						cur_time - $urandom_range(0, 3)));
				added += burst;
			end else begin
				if (r < 12)
					x = mk_load($urandom_range(0, 63), 16'($urandom),
						($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 16))
						: 16'($urandom));
				else if (r < 52)
					x = mk_spike($urandom_range(0, 63), cur_time - $urandom_range(0, 3));
				else if (r < 94) begin
					cur_time += $urandom_range(0, 6);
					ext = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 32'h40000) - 32'h20000
						: $urandom;
					md = ($urandom_range(0, 9) < 7) ? 32'h10000 : $urandom;
					vmv = ($urandom_range(0, 1) != 0) ? $urandom
						: $urandom_range(0, 32'hA00000) - 32'h500000;
					x = mk_tick(cur_time, vmv, ext, md);
				end else if (r < 97) begin
					x = mk_clear();
				end else begin
					noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
					x = noise[$bits(dsdes_pkg::in_word_t)-1:0];
				end
				pending_words.push_back(x);
				added++;
			end
		end
	endtask

	initial begin
		foreach (coef[i]) coef[i] = '0;
		foreach (tbl_weight[i]) begin
			tbl_weight[i] = '0;
			tbl_delay[i] = '0;
		end
		q_count = 0;
		filt_x = 0;
		filt_y = 0;
		drop_flag = 1'b0;
		cur_time = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// The synapse tables are cleared right after reset.
		while (busy) @(posedge clk);

		// Directed words: field extremes, equal due times, due-time saturation.
		set_coefs(0);
		pending_words.push_back(mk_load(0, 16'sh7FFF, 16'd0));
		pending_words.push_back(mk_load(63, 16'sh8000, 16'hFFFF));
		pending_words.push_back(mk_load(5, 16'sh0100, 16'd3));
		pending_words.push_back(mk_load(6, 16'sh0100, 16'd3));
		pending_words.push_back(mk_spike(0, 32'd10));
		pending_words.push_back(mk_spike(5, 32'd10));
		pending_words.push_back(mk_spike(6, 32'd10));
		pending_words.push_back(mk_spike(63, 32'hFFFFFFF0));
		pending_words.push_back(mk_tick(32'd9, 32'h0, 32'h0, 32'h10000));
		pending_words.push_back(mk_tick(32'd13, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h10000));
		pending_words.push_back(mk_tick(32'hFFFFFFFF, 32'h80000000, 32'h80000000,
			32'h80000000));
		pending_words.push_back(mk_tick(32'hFFFFFFFF, 32'h0, 32'h0, 32'h0));
		pending_words.push_back(mk_clear());
		pending_words.push_back(mk_tick(32'd0, 32'h7FFFFFFF, 32'h1000, 32'h10000));
		pending_words.push_back(mk_spike(0, 32'd0));
		pending_words.push_back(mk_spike(0, 32'd0));
		pending_words.push_back(mk_tick(32'd0, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF));
		pending_words.push_back(mk_tick(32'd1, 32'h12345678, 32'h0, 32'h10000));
		wait_idle();

		// Random phases, each under its own coefficient set; the sender stops
		// until every result is in before each reconfiguration.
		for (int p = 0; p < 8; p++) begin
			set_coefs(p % 4);
			quiet_sender = (p % 3 == 1);
			case (p % 3)
				0: cur_time = $urandom;
				1: cur_time = 32'hFFFFFF00;
				default: cur_time = 0;
			endcase
			add_random(215);
			wait_idle();
		end

		$display("checked %0d tick results over 8 random coefficient phases, %0d spikes dropped",
			ticks_checked, drops_seen);
		if (expected_words.size() != 0) mismatches++;
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("mismatches: %0d", mismatches);
			$display("status: fail");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/dsdes_pkg.sv
hw/rtl/dsdes_ram.sv
hw/rtl/dsdes_regs.sv
hw/rtl/delayed_spike_dual_exp_synapse_unit.sv
tb/delayed_spike_dual_exp_synapse_unit_test.sv
